@@ rtl/isort_pkg.sv @@
// ----------------------------------------------------------------------------
// isort_pkg - shared types and constants of the insertion sorter
// Holds the store depth, the value width, the link record between cells and
// the controller states.
// ----------------------------------------------------------------------------
package isort_pkg;

    localparam int DEPTH = 64;
    localparam int VAL_W = 32;

    // what one cell shows to its neighbors
    typedef struct packed {
        logic                    valid;
        logic                    ge;     // empty, or holds a key above the new one
        logic signed [VAL_W-1:0] key;
    } t_link;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

endpackage

@@ rtl/isort_cell.sv @@
// ----------------------------------------------------------------------------
// isort_cell - one slot of the insertion chain
// Holds one key; on insert it keeps its key, takes the new key or takes the
// key of its left neighbor; on drain it takes the key of its right neighbor.
// ----------------------------------------------------------------------------
module isort_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_ins,
    input  logic                               i_shift,
    input  logic signed [isort_pkg::VAL_W-1:0] i_new_key,
    input  isort_pkg::t_link                   i_left,
    input  logic                               i_right_valid,
    input  logic signed [isort_pkg::VAL_W-1:0] i_right_key,
    output isort_pkg::t_link                   o_link
);

    logic                               r_valid;
    logic signed [isort_pkg::VAL_W-1:0] r_key;
    logic                               w_ge;

    // strictly greater keeps equal keys in arrival order
    assign w_ge = !r_valid || (r_key > i_new_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_right_valid;
        end else if (i_ins && w_ge) begin
            r_valid <= i_left.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key <= i_right_key;
        end else if (i_ins && w_ge) begin
            r_key <= i_left.ge ? i_left.key : i_new_key;
        end
    end

    assign o_link.valid = r_valid;
    assign o_link.ge    = w_ge;
    assign o_link.key   = r_key;

endmodule

@@ rtl/insertion_sorter.sv @@
// ----------------------------------------------------------------------------
// insertion_sorter - streaming insertion sort over one batch
// Loads signed values into a sorted chain of cells, then drains them smallest
// first when the batch closes, flagging batches that ran past capacity.
// ----------------------------------------------------------------------------
//
//  port group   dir  tdata                     tlast            tuser
//  s_axis       in   [31:0] value              last             -
//  m_axis       out  [31:0] sorted_value       last_res         [0] overflow
//
//  load: one item per cycle, each placed by a broadcast compare in every cell
//  and a one-step shift of the larger keys to the right
//  drain: one stored value per accepted result, cell 0 drives the output
//  and the chain shifts left on each take
//  input stalls from the closing item until the final result is taken
//  reset (synchronous, active low) empties every cell and clears the flag
//  items past DEPTH stored values are dropped and set overflow for the batch
// ----------------------------------------------------------------------------
module insertion_sorter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic        i_s_axis_tlast,   // last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] sorted_value
    output logic        o_m_axis_tlast,   // last_res
    output logic [0:0]  o_m_axis_tuser    // [0] overflow
);

    localparam int D = isort_pkg::DEPTH;

    isort_pkg::t_state r_state, n_state;
    logic              r_ovf,   n_ovf;

    isort_pkg::t_link  w_link [D];
    logic              w_in_acc;
    logic              w_out_acc;
    logic              w_full;
    logic              w_ins;
    logic              w_shift;
    logic              w_final;

    assign w_full    = w_link[D-1].valid;
    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;
    assign w_ins     = w_in_acc && !w_full;
    assign w_shift   = w_out_acc;
    // final result: the cell behind the head is empty
    assign w_final   = !w_link[1].valid;

    // ---- chain of cells ----
    for (genvar g = 0; g < D; g++) begin : g_cell
        isort_pkg::t_link                   w_left;
        logic                               w_rv;
        logic signed [isort_pkg::VAL_W-1:0] w_rk;

        if (g == 0) begin : g_head
            // the head behaves as if a smaller valid key sat to its left
            assign w_left.valid = 1'b1;
            assign w_left.ge    = 1'b0;
            assign w_left.key   = '0;
        end else begin : g_body
            assign w_left = w_link[g-1];
        end

        if (g == D-1) begin : g_tail
            assign w_rv = 1'b0;
            assign w_rk = '0;
        end else begin : g_mid
            assign w_rv = w_link[g+1].valid;
            assign w_rk = w_link[g+1].key;
        end

        isort_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ins        (w_ins),
            .i_shift      (w_shift),
            .i_new_key    ($signed(i_s_axis_tdata)),
            .i_left       (w_left),
            .i_right_valid(w_rv),
            .i_right_key  (w_rk),
            .o_link       (w_link[g])
        );
    end

    // ---- batch control ----
    always_comb begin
        n_state = r_state;
        n_ovf   = r_ovf;
        unique case (r_state)
            isort_pkg::ST_LOAD: begin
                if (w_in_acc && w_full) begin
                    n_ovf = 1'b1;
                end
                if (w_in_acc && i_s_axis_tlast) begin
                    n_state = isort_pkg::ST_DRAIN;
                end
            end
            isort_pkg::ST_DRAIN: begin
                if (w_out_acc && w_final) begin
                    n_state = isort_pkg::ST_LOAD;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = isort_pkg::ST_LOAD;
                n_ovf   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= isort_pkg::ST_LOAD;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovf   <= n_ovf;
        end
    end

    // ---- ports ----
    assign o_s_axis_tready   = (r_state == isort_pkg::ST_LOAD);
    assign o_m_axis_tvalid   = (r_state == isort_pkg::ST_DRAIN) && w_link[0].valid;
    assign o_m_axis_tdata    = w_link[0].key;
    assign o_m_axis_tlast    = w_final;
    assign o_m_axis_tuser[0] = r_ovf;

    // ---- checks ----
    a_drain_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == isort_pkg::ST_DRAIN) |-> w_link[0].valid)
        else $error("drain state with an empty head cell");

    a_close_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_axis_tlast) |=> (r_state == isort_pkg::ST_DRAIN))
        else $error("closing item did not start the drain");

    a_ovf_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> $past(w_full))
        else $error("overflow flagged while the chain had room");

    a_final_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && w_final) |=> (!w_link[0].valid && !r_ovf))
        else $error("chain not empty after the final result");

    a_full_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> (w_link[0].valid && w_link[1].valid))
        else $error("valid cells do not form a prefix");

endmodule
